### src/cwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning classifier package
// Payload types, register indexes, level codes and fixed-point constants.
// ----------------------------------------------------------------------------
package cwc_pkg;

    localparam int DIST_W    = 10;
    localparam int SPEED_W   = 12;
    localparam int TTC_W     = 15;
    localparam int TTC_FRAC  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // Dividend is front * 36 * 2^TTC_FRAC, divisor is speed * 100.
    localparam int NUM_W  = 24;
    localparam int DEN_W  = 19;
    localparam int Q_BITS = 15;
    localparam int DSH_W  = DEN_W + Q_BITS - 1;
    localparam int CNT_W  = 4;

    localparam logic [NUM_W-1:0]   TTC_SCALE = NUM_W'(36);
    localparam logic [DEN_W-1:0]   SPEED_SCALE = DEN_W'(100);
    localparam logic [SPEED_W-1:0] MIN_SPEED = SPEED_W'(4);
    localparam logic [TTC_W-1:0]   TTC_SAT = TTC_W'(99 << TTC_FRAC);
    localparam logic [3:0]         RUN_MAX = 4'd15;

    localparam logic [1:0] LVL_SAFE     = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_DISTANCE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_DISTANCE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_TTC      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_TTC       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_SAMPLES     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_SPEED       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_DISTANCE    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PARKING_SPEED     = 4'd7;

    typedef struct packed {
        logic [DIST_W-1:0]  front_distance;
        logic [DIST_W-1:0]  left_distance;
        logic [DIST_W-1:0]  right_distance;
        logic [SPEED_W-1:0] vehicle_speed;
    } t_cwc_in;

    typedef struct packed {
        logic [1:0]       threat_level;
        logic             fault_flag;
        logic [TTC_W-1:0] time_to_collision;
        logic             blind_left_flag;
        logic             blind_right_flag;
        logic             parking_flag;
    } t_cwc_out;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_cwc_state;

endpackage

### src/collision_warning_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning classifier
// Time-to-collision divider, level classification and side/parking flags.
// ----------------------------------------------------------------------------
// Each request occupies the block until its result is loaded: the accepting
// edge loads the divider, a restoring divider then yields the 15 quotient
// bits, one quotient bit per cycle, and a final state classifies and loads
// the output register. The block returns to idle as the result becomes
// valid, so the next request can be taken while that result is presented,
// but not before the last one is through. The input is not ready while a
// request is in progress or while a finished result cannot yet be placed in
// the output register. Configuration writes are always taken and should
// only be issued while the block is idle.
module collision_warning_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cwc_pkg::t_cwc_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cwc_pkg::t_cwc_out             o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cwc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import cwc_pkg::*;

    // Control state
    t_cwc_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_level, n_level;
    logic             r_fault, n_fault;
    logic [3:0]       r_run, n_run;
    logic             r_out_valid, n_out_valid;

    // Configuration
    logic [DIST_W-1:0]  r_crit_dist, r_warn_dist, r_blind_dist;
    logic [TTC_W-1:0]   r_crit_ttc, r_warn_ttc;
    logic [3:0]         r_clear_samples;
    logic [SPEED_W-1:0] r_blind_speed, r_park_speed;

    // Datapath
    t_cwc_in           r_item;
    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [DSH_W-1:0]  r_den_sh, n_den_sh;
    logic [Q_BITS-1:0] r_quo, n_quo;
    t_cwc_out          r_out, n_out;

    logic              in_fire, div_ge, load_out, blind_on;
    logic [TTC_W-1:0]  ttc;
    logic [3:0]        run_inc;
    logic [DEN_W-1:0]  den;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign den    = DEN_W'(i_in.vehicle_speed) * SPEED_SCALE;
    assign div_ge = {{(DSH_W-NUM_W){1'b0}}, r_rem} >= r_den_sh;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_item.vehicle_speed < MIN_SPEED) begin
            ttc = TTC_SAT;
        end else if (TTC_W'(r_quo) > TTC_SAT) begin
            ttc = TTC_SAT;
        end else begin
            ttc = TTC_W'(r_quo);
        end
    end

    assign blind_on = r_item.vehicle_speed > r_blind_speed;
    assign run_inc  = (r_run < RUN_MAX) ? r_run + 4'd1 : r_run;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_level     = r_level;
        n_fault     = r_fault;
        n_run       = r_run;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rem       = r_rem;
        n_den_sh    = r_den_sh;
        n_quo       = r_quo;
        n_out       = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_rem    = (NUM_W'(i_in.front_distance) * TTC_SCALE) << TTC_FRAC;
                    n_den_sh = DSH_W'(den) << (Q_BITS - 1);
                    n_quo    = '0;
                    n_cnt    = CNT_W'(Q_BITS - 1);
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                // The quotient always fits in Q_BITS because the speed is
                // at least MIN_SPEED whenever the quotient is used.
                if (div_ge) begin
                    n_rem = r_rem - r_den_sh[NUM_W-1:0];
                end
                n_quo    = {r_quo[Q_BITS-2:0], div_ge};
                n_den_sh = r_den_sh >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    priority if (r_item.front_distance < r_crit_dist ||
                                 ttc < r_crit_ttc) begin
                        n_level = LVL_CRITICAL;
                        n_fault = 1'b1;
                    end else if (r_item.front_distance < r_warn_dist ||
                                 ttc < r_warn_ttc) begin
                        n_level = LVL_WARNING;
                        n_run   = '0;
                    end else if (run_inc >= r_clear_samples) begin
                        n_level = LVL_SAFE;
                        n_fault = 1'b0;
                        n_run   = '0;
                    end else begin
                        n_run = run_inc;
                    end
                    n_out.threat_level      = n_level;
                    n_out.fault_flag        = n_fault;
                    n_out.time_to_collision = ttc;
                    n_out.blind_left_flag   = blind_on &&
                                              (r_item.left_distance < r_blind_dist);
                    n_out.blind_right_flag  = blind_on &&
                                              (r_item.right_distance < r_blind_dist);
                    n_out.parking_flag      = r_item.vehicle_speed < r_park_speed;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_cnt           <= '0;
            r_level         <= LVL_SAFE;
            r_fault         <= 1'b0;
            r_run           <= '0;
            r_out_valid     <= 1'b0;
            r_crit_dist     <= DIST_W'(20);
            r_warn_dist     <= DIST_W'(50);
            r_crit_ttc      <= TTC_W'(384);
            r_warn_ttc      <= TTC_W'(768);
            r_clear_samples <= 4'd3;
            r_blind_speed   <= SPEED_W'(200);
            r_blind_dist    <= DIST_W'(30);
            r_park_speed    <= SPEED_W'(100);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_level     <= n_level;
            r_fault     <= n_fault;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                // Indexes beyond the register list are ignored.
                if (i_cfg_index == REG_CRITICAL_DISTANCE) begin
                    r_crit_dist <= i_cfg_data[DIST_W-1:0];
                end
                if (i_cfg_index == REG_WARNING_DISTANCE) begin
                    r_warn_dist <= i_cfg_data[DIST_W-1:0];
                end
                if (i_cfg_index == REG_CRITICAL_TTC) begin
                    r_crit_ttc <= i_cfg_data[TTC_W-1:0];
                end
                if (i_cfg_index == REG_WARNING_TTC) begin
                    r_warn_ttc <= i_cfg_data[TTC_W-1:0];
                end
                if (i_cfg_index == REG_CLEAR_SAMPLES) begin
                    r_clear_samples <= i_cfg_data[3:0];
                end
                if (i_cfg_index == REG_BLIND_SPEED) begin
                    r_blind_speed <= i_cfg_data[SPEED_W-1:0];
                end
                if (i_cfg_index == REG_BLIND_DISTANCE) begin
                    r_blind_dist <= i_cfg_data[DIST_W-1:0];
                end
                if (i_cfg_index == REG_PARKING_SPEED) begin
                    r_park_speed <= i_cfg_data[SPEED_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in;
        end
        r_rem    <= n_rem;
        r_den_sh <= n_den_sh;
        r_quo    <= n_quo;
        r_out    <= n_out;
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_DIV))
        else $error("accepted request did not start the divider");

    a_fault_not_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> (r_level != LVL_SAFE))
        else $error("fault flag set while level is safe");

    a_level_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == LVL_SAFE) || (r_level == LVL_WARNING) || (r_level == LVL_CRITICAL))
        else $error("level register holds an unused code");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared without a finished request");

endmodule
